>>> sv/spi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants for the segment pair intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

	localparam int FIELD_W = 32;

	typedef struct packed {
		logic hit;
		logic col;
		logic p1q;
		logic p2q;
		logic q1p;
		logic q2p;
	} spi_flags_t;

	// how the back end forms the crossing point
	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_P1   = 2'd1,
		MODE_DIV  = 2'd2
	} spi_mode_t;

endpackage

>>> sv/spi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_front
// Front end: orientations, on-segment tests and classification of each pair.
// ----------------------------------------------------------------------------
module spi_front #(
	parameter int CW = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            start,
	input  logic [spi_pkg::FIELD_W-1:0]     p1_x,
	input  logic [spi_pkg::FIELD_W-1:0]     p1_y,
	input  logic [spi_pkg::FIELD_W-1:0]     p2_x,
	input  logic [spi_pkg::FIELD_W-1:0]     p2_y,
	input  logic [spi_pkg::FIELD_W-1:0]     q1_x,
	input  logic [spi_pkg::FIELD_W-1:0]     q1_y,
	input  logic [spi_pkg::FIELD_W-1:0]     q2_x,
	input  logic [spi_pkg::FIELD_W-1:0]     q2_y,
	output logic                            out_valid,
	output spi_pkg::spi_flags_t             flags,
	output spi_pkg::spi_mode_t              mode,
	output logic signed [2*CW+2:0]          den,
	output logic signed [2*CW+2:0]          num,
	output logic signed [CW:0]              rx,
	output logic signed [CW:0]              ry,
	output logic signed [CW-1:0]            p1x,
	output logic signed [CW-1:0]            p1y
);
	import spi_pkg::*;

	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 2;
	localparam int OW = 2 * CW + 3;

	function automatic logic signed [DW-1:0] dif(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		return DW'(a) - DW'(b);
	endfunction

	function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
		input logic signed [DW-1:0] b);
		return PW'(a) * PW'(b);
	endfunction

	function automatic logic inrange(input logic signed [CW-1:0] v,
		input logic signed [CW-1:0] e0, input logic signed [CW-1:0] e1);
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
		lo = (e1 < e0) ? e1 : e0;
		hi = (e1 < e0) ? e0 : e1;
		return (v >= lo) && (v <= hi);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [CW-1:0] p1x_s1, p1y_s1, p2x_s1, p2y_s1;
	logic signed [CW-1:0] q1x_s1, q1y_s1, q2x_s1, q2y_s1;

	logic signed [DW-1:0] rx_s2, ry_s2, sx_s2, sy_s2, dx_s2, dy_s2;
	logic signed [DW-1:0] ex_s2, ey_s2, gx_s2, gy_s2;
	logic signed [CW-1:0] p1x_s2, p1y_s2;
	logic [3:0]           bb_s2;

	logic signed [PW-1:0] m_s3 [8];
	logic signed [DW-1:0] rx_s3, ry_s3;
	logic signed [CW-1:0] p1x_s3, p1y_s3;
	logic [3:0]           bb_s3;

	logic signed [OW-1:0] o_s4 [4];
	logic signed [DW-1:0] rx_s4, ry_s4;
	logic signed [CW-1:0] p1x_s4, p1y_s4;
	logic [3:0]           bb_s4;

	spi_flags_t           fl_s5;
	logic signed [OW-1:0] den_s5, num_s5;
	logic signed [DW-1:0] rx_s5, ry_s5;
	logic signed [CW-1:0] p1x_s5, p1y_s5;

	logic [3:0]  z;
	logic [3:0]  n;
	spi_flags_t  fl;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			z[i] = (o_s4[i] == '0);
			n[i] = o_s4[i][OW-1];
		end
		fl.q1p = z[0] & bb_s4[0];
		fl.q2p = z[1] & bb_s4[1];
		fl.p1q = z[2] & bb_s4[2];
		fl.p2q = z[3] & bb_s4[3];
		fl.col = z[0] & z[1];
		fl.hit = fl.q1p | fl.q2p | fl.p1q | fl.p2q |
			(({z[0], n[0]} != {z[1], n[1]}) && ({z[2], n[2]} != {z[3], n[3]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1x_s1 <= p1_x[CW-1:0];
			p1y_s1 <= p1_y[CW-1:0];
			p2x_s1 <= p2_x[CW-1:0];
			p2y_s1 <= p2_y[CW-1:0];
			q1x_s1 <= q1_x[CW-1:0];
			q1y_s1 <= q1_y[CW-1:0];
			q2x_s1 <= q2_x[CW-1:0];
			q2y_s1 <= q2_y[CW-1:0];

			rx_s2  <= dif(p2x_s1, p1x_s1);
			ry_s2  <= dif(p2y_s1, p1y_s1);
			sx_s2  <= dif(q2x_s1, q1x_s1);
			sy_s2  <= dif(q2y_s1, q1y_s1);
			dx_s2  <= dif(q1x_s1, p1x_s1);
			dy_s2  <= dif(q1y_s1, p1y_s1);
			ex_s2  <= dif(q2x_s1, p1x_s1);
			ey_s2  <= dif(q2y_s1, p1y_s1);
			gx_s2  <= dif(p2x_s1, q1x_s1);
			gy_s2  <= dif(p2y_s1, q1y_s1);
			p1x_s2 <= p1x_s1;
			p1y_s2 <= p1y_s1;
			bb_s2[0] <= inrange(q1x_s1, p1x_s1, p2x_s1) && inrange(q1y_s1, p1y_s1, p2y_s1);
			bb_s2[1] <= inrange(q2x_s1, p1x_s1, p2x_s1) && inrange(q2y_s1, p1y_s1, p2y_s1);
			bb_s2[2] <= inrange(p1x_s1, q1x_s1, q2x_s1) && inrange(p1y_s1, q1y_s1, q2y_s1);
			bb_s2[3] <= inrange(p2x_s1, q1x_s1, q2x_s1) && inrange(p2y_s1, q1y_s1, q2y_s1);

			m_s3[0] <= mul(rx_s2, dy_s2);
			m_s3[1] <= mul(ry_s2, dx_s2);
			m_s3[2] <= mul(rx_s2, ey_s2);
			m_s3[3] <= mul(ry_s2, ex_s2);
			m_s3[4] <= mul(sy_s2, dx_s2);
			m_s3[5] <= mul(sx_s2, dy_s2);
			m_s3[6] <= mul(sx_s2, gy_s2);
			m_s3[7] <= mul(sy_s2, gx_s2);
			rx_s3   <= rx_s2;
			ry_s3   <= ry_s2;
			p1x_s3  <= p1x_s2;
			p1y_s3  <= p1y_s2;
			bb_s3   <= bb_s2;

			for (int i = 0; i < 4; i++) begin
				o_s4[i] <= OW'(m_s3[2*i]) - OW'(m_s3[2*i+1]);
			end
			rx_s4  <= rx_s3;
			ry_s4  <= ry_s3;
			p1x_s4 <= p1x_s3;
			p1y_s4 <= p1y_s3;
			bb_s4  <= bb_s3;

			fl_s5  <= fl;
			den_s5 <= o_s4[1] - o_s4[0];
			num_s5 <= o_s4[2];
			rx_s5  <= rx_s4;
			ry_s5  <= ry_s4;
			p1x_s5 <= p1x_s4;
			p1y_s5 <= p1y_s4;
		end
	end

	always_comb begin
		priority if (!fl_s5.hit || fl_s5.col) begin
			mode = MODE_ZERO;
		end else if (den_s5 == '0) begin
			mode = MODE_P1;
		end else begin
			mode = MODE_DIV;
		end
	end

	assign out_valid = v_s5;
	assign flags     = fl_s5;
	assign den       = den_s5;
	assign num       = num_s5;
	assign rx        = rx_s5;
	assign ry        = ry_s5;
	assign p1x       = p1x_s5;
	assign p1y       = p1y_s5;

endmodule

>>> sv/spi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_queue
// Two-entry queue between front and back end; drains one entry per cycle.
// ----------------------------------------------------------------------------
module spi_queue #(
	parameter int EW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [EW-1:0] din,
	output logic          out_valid,
	output logic [EW-1:0] dout,
	output logic          full
);
	localparam int DEPTH = 2;

	logic [EW-1:0] mem_q [DEPTH];
	logic          wr_q, rd_q;
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop       = (cnt_q != 2'd0);
	assign out_valid = pop;
	assign full      = (cnt_q == 2'(DEPTH));
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> sv/spi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_div
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// ----------------------------------------------------------------------------
module spi_div #(
	parameter int MW  = 98,
	parameter int DVW = 67,
	parameter int QB  = 32,
	parameter int SW  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [MW-1:0]  rem_in,
	input  logic [DVW-1:0] dv_in,
	input  logic [SW-1:0]  side_in,
	output logic           out_valid,
	output logic [QB-1:0]  q_out,
	output logic [SW-1:0]  side_out
);
	logic           v_q   [QB+1];
	logic [MW-1:0]  rem_q [QB+1];
	logic [DVW-1:0] dv_q  [QB+1];
	logic [QB-1:0]  quo_q [QB+1];
	logic [SW-1:0]  sd_q  [QB+1];

	assign v_q[0]   = in_valid;
	assign rem_q[0] = rem_in;
	assign dv_q[0]  = dv_in;
	assign quo_q[0] = '0;
	assign sd_q[0]  = side_in;

	for (genvar k = 0; k < QB; k++) begin : g_stg
		localparam int SH = QB - 1 - k;
		logic [MW-1:0] trial;
		logic          ge;

		assign trial = MW'(dv_q[k]) << SH;
		assign ge    = (rem_q[k] >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? (rem_q[k] - trial) : rem_q[k];
			dv_q[k+1]  <= dv_q[k];
			quo_q[k+1] <= {quo_q[k][QB-2:0], ge};
			sd_q[k+1]  <= sd_q[k];
		end
	end

	assign out_valid = v_q[QB];
	assign q_out     = quo_q[QB];
	assign side_out  = sd_q[QB];

endmodule

>>> sv/spi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_back
// Back end: exact crossing point numerators, rounding division, result register.
// ----------------------------------------------------------------------------
module spi_back #(
	parameter int CW = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  spi_pkg::spi_flags_t         in_flags,
	input  spi_pkg::spi_mode_t          in_mode,
	input  logic signed [2*CW+2:0]      den,
	input  logic signed [2*CW+2:0]      num,
	input  logic signed [CW:0]          rx,
	input  logic signed [CW:0]          ry,
	input  logic signed [CW-1:0]        p1x,
	input  logic signed [CW-1:0]        p1y,
	output logic                        done,
	output spi_pkg::spi_flags_t         flags,
	output logic [spi_pkg::FIELD_W-1:0] cross_x,
	output logic [spi_pkg::FIELD_W-1:0] cross_y
);
	import spi_pkg::*;

	localparam int DW  = CW + 1;
	localparam int OW  = 2 * CW + 3;
	localparam int L   = CW + 1;
	localparam int HW  = OW - L;
	localparam int PPW = 2 * CW + 3;
	localparam int NW  = 3 * CW + 4;
	localparam int MW  = 3 * CW + 2;
	localparam int DVW = 2 * CW + 3;

	typedef struct packed {
		spi_flags_t           fl;
		spi_mode_t            md;
		logic signed [CW-1:0] p1;
		logic                 neg;
	} side_x_t;

	typedef struct packed {
		logic signed [CW-1:0] p1;
		logic                 neg;
	} side_y_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	spi_flags_t fl_s1, fl_s2, fl_s3, fl_s4, fl_s5;
	spi_mode_t  md_s1, md_s2, md_s3, md_s4, md_s5;
	logic signed [CW-1:0] p1x_s1, p1x_s2, p1x_s3, p1x_s4, p1x_s5;
	logic signed [CW-1:0] p1y_s1, p1y_s2, p1y_s3, p1y_s4, p1y_s5;
	logic signed [OW-1:0] dabs_s1, dabs_s2, dabs_s3, dabs_s4, dabs_s5;
	logic signed [OW-1:0] num_s1;
	logic signed [DW-1:0] rx_s1, ry_s1;

	logic signed [PPW-1:0] pxl_s2, pxh_s2, rxl_s2, rxh_s2;
	logic signed [PPW-1:0] pyl_s2, pyh_s2, ryl_s2, ryh_s2;
	logic signed [NW-1:0]  ax_s3, bx_s3, ay_s3, by_s3;
	logic signed [NW-1:0]  nx_s4, ny_s4;
	logic [NW-1:0]         magx_s5, magy_s5;
	logic                  negx_s5, negy_s5;
	logic [MW-1:0]         mx_s6, my_s6;
	logic [DVW-1:0]        dv_s6;
	side_x_t               sx_s6;
	side_y_t               sy_s6;

	logic signed [L:0]    dlo, nlo;
	logic signed [HW-1:0] dhi, nhi;
	logic                 dneg;

	logic                 vx_d, vy_d;
	logic [CW-1:0]        qx_d, qy_d;
	logic [$bits(side_x_t)-1:0] sxo;
	logic [$bits(side_y_t)-1:0] syo;
	side_x_t              sx_d;
	side_y_t              sy_d;
	logic signed [CW-1:0] valx, valy;
	logic [FIELD_W-1:0]   cx_n, cy_n;

	logic                 done_q;
	spi_flags_t           fl_q;
	logic [FIELD_W-1:0]   cx_q, cy_q;

	assign dneg = den[OW-1];
	assign dlo  = $signed({1'b0, dabs_s1[L-1:0]});
	assign dhi  = dabs_s1[OW-1:L];
	assign nlo  = $signed({1'b0, num_s1[L-1:0]});
	assign nhi  = num_s1[OW-1:L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// normalize to a positive denominator
		dabs_s1 <= dneg ? -den : den;
		num_s1  <= dneg ? -num : num;
		rx_s1   <= rx;
		ry_s1   <= ry;
		p1x_s1  <= p1x;
		p1y_s1  <= p1y;
		fl_s1   <= in_flags;
		md_s1   <= in_mode;

		pxl_s2  <= PPW'(p1x_s1) * PPW'(dlo);
		pxh_s2  <= PPW'(p1x_s1) * PPW'(dhi);
		rxl_s2  <= PPW'(rx_s1) * PPW'(nlo);
		rxh_s2  <= PPW'(rx_s1) * PPW'(nhi);
		pyl_s2  <= PPW'(p1y_s1) * PPW'(dlo);
		pyh_s2  <= PPW'(p1y_s1) * PPW'(dhi);
		ryl_s2  <= PPW'(ry_s1) * PPW'(nlo);
		ryh_s2  <= PPW'(ry_s1) * PPW'(nhi);
		dabs_s2 <= dabs_s1;
		p1x_s2  <= p1x_s1;
		p1y_s2  <= p1y_s1;
		fl_s2   <= fl_s1;
		md_s2   <= md_s1;

		ax_s3   <= (NW'(pxh_s2) <<< L) + NW'(pxl_s2);
		bx_s3   <= (NW'(rxh_s2) <<< L) + NW'(rxl_s2);
		ay_s3   <= (NW'(pyh_s2) <<< L) + NW'(pyl_s2);
		by_s3   <= (NW'(ryh_s2) <<< L) + NW'(ryl_s2);
		dabs_s3 <= dabs_s2;
		p1x_s3  <= p1x_s2;
		p1y_s3  <= p1y_s2;
		fl_s3   <= fl_s2;
		md_s3   <= md_s2;

		nx_s4   <= ax_s3 + bx_s3;
		ny_s4   <= ay_s3 + by_s3;
		dabs_s4 <= dabs_s3;
		p1x_s4  <= p1x_s3;
		p1y_s4  <= p1y_s3;
		fl_s4   <= fl_s3;
		md_s4   <= md_s3;

		negx_s5 <= nx_s4[NW-1];
		negy_s5 <= ny_s4[NW-1];
		magx_s5 <= nx_s4[NW-1] ? -nx_s4 : nx_s4;
		magy_s5 <= ny_s4[NW-1] ? -ny_s4 : ny_s4;
		dabs_s5 <= dabs_s4;
		p1x_s5  <= p1x_s4;
		p1y_s5  <= p1y_s4;
		fl_s5   <= fl_s4;
		md_s5   <= md_s4;

		// round half away from zero: (2|n| + d) / (2d)
		mx_s6  <= MW'({magx_s5, 1'b0}) + MW'(dabs_s5);
		my_s6  <= MW'({magy_s5, 1'b0}) + MW'(dabs_s5);
		dv_s6  <= DVW'({dabs_s5, 1'b0});
		sx_s6  <= '{fl: fl_s5, md: md_s5, p1: p1x_s5, neg: negx_s5};
		sy_s6  <= '{p1: p1y_s5, neg: negy_s5};
	end

	spi_div #(
		.MW (MW),
		.DVW(DVW),
		.QB (CW),
		.SW ($bits(side_x_t))
	) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.rem_in   (mx_s6),
		.dv_in    (dv_s6),
		.side_in  (sx_s6),
		.out_valid(vx_d),
		.q_out    (qx_d),
		.side_out (sxo)
	);

	spi_div #(
		.MW (MW),
		.DVW(DVW),
		.QB (CW),
		.SW ($bits(side_y_t))
	) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.rem_in   (my_s6),
		.dv_in    (dv_s6),
		.side_in  (sy_s6),
		.out_valid(vy_d),
		.q_out    (qy_d),
		.side_out (syo)
	);

	assign sx_d = side_x_t'(sxo);
	assign sy_d = side_y_t'(syo);
	assign valx = sx_d.neg ? -$signed(qx_d) : $signed(qx_d);
	assign valy = sy_d.neg ? -$signed(qy_d) : $signed(qy_d);

	always_comb begin
		unique case (sx_d.md)
			MODE_DIV: begin
				cx_n = FIELD_W'(valx);
				cy_n = FIELD_W'(valy);
			end
			MODE_P1: begin
				cx_n = FIELD_W'(sx_d.p1);
				cy_n = FIELD_W'(sy_d.p1);
			end
			default: begin
				cx_n = '0;
				cy_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx_d & vy_d;
		end
	end

	always_ff @(posedge clk) begin
		fl_q <= sx_d.fl;
		cx_q <= cx_n;
		cy_q <= cy_n;
	end

	assign done    = done_q;
	assign flags   = fl_q;
	assign cross_x = cx_q;
	assign cross_y = cy_q;

endmodule

>>> sv/segment_pair_intersection.sv
`timescale 1ns / 1ps
// done strobes once a pair has passed the front end, the queue, the back end, the dividers and the result register.
// Throughput: one pair per cycle; start is taken whenever busy is low.
// The pipeline depth grows with the restoring divider, one quotient bit per stage (COORD_WIDTH stages).
// busy rises only if the two-entry queue fills; the back end drains it every cycle.
// Reset (arst_n low) empties the pipeline and queue; items in flight are dropped.
// ----------------------------------------------------------------------------
// segment_pair_intersection
// Exact integer test of two segments with rounded crossing point.
// ----------------------------------------------------------------------------
module segment_pair_intersection #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [spi_pkg::FIELD_W-1:0] p1_x,
	input  logic [spi_pkg::FIELD_W-1:0] p1_y,
	input  logic [spi_pkg::FIELD_W-1:0] p2_x,
	input  logic [spi_pkg::FIELD_W-1:0] p2_y,
	input  logic [spi_pkg::FIELD_W-1:0] q1_x,
	input  logic [spi_pkg::FIELD_W-1:0] q1_y,
	input  logic [spi_pkg::FIELD_W-1:0] q2_x,
	input  logic [spi_pkg::FIELD_W-1:0] q2_y,
	output logic                        done,
	output logic                        intersects,
	output logic                        is_collinear,
	output logic                        p1_on_second,
	output logic                        p2_on_second,
	output logic                        q1_on_first,
	output logic                        q2_on_first,
	output logic [spi_pkg::FIELD_W-1:0] cross_x,
	output logic [spi_pkg::FIELD_W-1:0] cross_y
);
	import spi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int OW = 2 * CW + 3;
	localparam int EW = $bits(spi_flags_t) + $bits(spi_mode_t) + 2 * OW + 2 * (CW + 1) + 2 * CW;

	logic                 f_valid, q_full, q_valid, push;
	spi_flags_t           f_flags, b_in_flags, b_flags;
	spi_mode_t            f_mode, b_in_mode;
	logic signed [OW-1:0] f_den, f_num, b_den, b_num;
	logic signed [CW:0]   f_rx, f_ry, b_rx, b_ry;
	logic signed [CW-1:0] f_p1x, f_p1y, b_p1x, b_p1y;
	logic [EW-1:0]        q_din, q_dout;

	assign busy = q_full;
	assign push = f_valid & ~q_full;

	spi_front #(.CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (~q_full),
		.start    (start),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.q1_x     (q1_x),
		.q1_y     (q1_y),
		.q2_x     (q2_x),
		.q2_y     (q2_y),
		.out_valid(f_valid),
		.flags    (f_flags),
		.mode     (f_mode),
		.den      (f_den),
		.num      (f_num),
		.rx       (f_rx),
		.ry       (f_ry),
		.p1x      (f_p1x),
		.p1y      (f_p1y)
	);

	assign q_din = {f_flags, f_mode, f_den, f_num, f_rx, f_ry, f_p1x, f_p1y};

	spi_queue #(.EW(EW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (q_din),
		.out_valid(q_valid),
		.dout     (q_dout),
		.full     (q_full)
	);

	assign {b_in_flags, b_in_mode, b_den, b_num, b_rx, b_ry, b_p1x, b_p1y} = q_dout;

	spi_back #(.CW(CW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(q_valid),
		.in_flags(b_in_flags),
		.in_mode (b_in_mode),
		.den     (b_den),
		.num     (b_num),
		.rx      (b_rx),
		.ry      (b_ry),
		.p1x     (b_p1x),
		.p1y     (b_p1y),
		.done    (done),
		.flags   (b_flags),
		.cross_x (cross_x),
		.cross_y (cross_y)
	);

	assign intersects   = b_flags.hit;
	assign is_collinear = b_flags.col;
	assign p1_on_second = b_flags.p1q;
	assign p2_on_second = b_flags.p2q;
	assign q1_on_first  = b_flags.q1p;
	assign q2_on_first  = b_flags.q2p;

endmodule

>>> sv/spi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_checker
// Port-level checks of the segment pair intersection block, bound to the top.
// ----------------------------------------------------------------------------
module spi_checker #(
	parameter int COORD_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        intersects,
	input logic        is_collinear,
	input logic        p1_on_second,
	input logic        p2_on_second,
	input logic        q1_on_first,
	input logic        q2_on_first,
	input logic [31:0] cross_x,
	input logic [31:0] cross_y
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(COORD_WIDTH + 13) done)
		else $error("result transfer missing at fixed latency");

	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (!intersects || is_collinear)) |-> (cross_x == 32'd0 && cross_y == 32'd0))
		else $error("crossing point not zero without a proper crossing");

	a_touch_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (p1_on_second || p2_on_second || q1_on_first || q2_on_first)) |-> intersects)
		else $error("endpoint touch without intersect flag");

	a_both_on: assert property (@(posedge clk) disable iff (!arst_n)
		(done && q1_on_first && q2_on_first) |-> is_collinear)
		else $error("both second endpoints on first segment but not collinear");

endmodule

bind segment_pair_intersection spi_checker #(.COORD_WIDTH(COORD_WIDTH)) u_spi_checker (.*);
